@@ rtl/gwfg_pkg.sv @@
package gwfg_pkg;

    localparam int EXP_ADDR_BITS_DEF = 8;
    localparam int CFG_INDEX_W       = 8;
    localparam int DIV_STEPS         = 20;
    localparam int DIV_CNT_W         = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = CFG_INDEX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DD,
        ST_MUL_SS,
        ST_CHECK,
        ST_DIV,
        ST_TAB,
        ST_INTERP,
        ST_PROD,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_ACC,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DD,
        OP_SS,
        OP_CHECK,
        OP_DIV,
        OP_TAB,
        OP_INTERP,
        OP_PROD,
        OP_MHI,
        OP_MLO,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic width_zero;
        logic tail;
        logic last;
        logic out_busy;
    } status_t;

endpackage

@@ rtl/gwfg_ctrl.sv @@
module gwfg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gwfg_pkg::status_t status,
    output gwfg_pkg::cmd_t    cmd
);

    gwfg_pkg::state_t state_reg, state_next;
    logic [gwfg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gwfg_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = gwfg_pkg::OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            gwfg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = gwfg_pkg::OP_LOAD;
                    state_next = gwfg_pkg::ST_MUL_DD;
                end
            end
            gwfg_pkg::ST_MUL_DD: begin
                cmd.op     = gwfg_pkg::OP_DD;
                state_next = gwfg_pkg::ST_MUL_SS;
            end
            gwfg_pkg::ST_MUL_SS: begin
                cmd.op     = gwfg_pkg::OP_SS;
                state_next = status.width_zero ? gwfg_pkg::ST_FINISH : gwfg_pkg::ST_CHECK;
            end
            gwfg_pkg::ST_CHECK: begin
                cmd.op     = gwfg_pkg::OP_CHECK;
                cnt_next   = '0;
                state_next = status.tail ? gwfg_pkg::ST_PROD : gwfg_pkg::ST_DIV;
            end
            gwfg_pkg::ST_DIV: begin
                cmd.op   = gwfg_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gwfg_pkg::DIV_CNT_W'(gwfg_pkg::DIV_STEPS - 1)) begin
                    state_next = gwfg_pkg::ST_TAB;
                end
            end
            gwfg_pkg::ST_TAB: begin
                cmd.op     = gwfg_pkg::OP_TAB;
                state_next = gwfg_pkg::ST_INTERP;
            end
            gwfg_pkg::ST_INTERP: begin
                cmd.op     = gwfg_pkg::OP_INTERP;
                state_next = gwfg_pkg::ST_PROD;
            end
            gwfg_pkg::ST_PROD: begin
                cmd.op     = gwfg_pkg::OP_PROD;
                state_next = gwfg_pkg::ST_MUL_HI;
            end
            gwfg_pkg::ST_MUL_HI: begin
                cmd.op     = gwfg_pkg::OP_MHI;
                state_next = gwfg_pkg::ST_MUL_LO;
            end
            gwfg_pkg::ST_MUL_LO: begin
                cmd.op     = gwfg_pkg::OP_MLO;
                state_next = gwfg_pkg::ST_ACC;
            end
            gwfg_pkg::ST_ACC: begin
                cmd.op     = gwfg_pkg::OP_ACC;
                state_next = gwfg_pkg::ST_FINISH;
            end
            gwfg_pkg::ST_FINISH: begin
                if (!status.last) begin
                    state_next = gwfg_pkg::ST_IDLE;
                end else if (!status.out_busy) begin
                    cmd.op     = gwfg_pkg::OP_EMIT;
                    state_next = gwfg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gwfg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/gwfg_dp.sv @@
module gwfg_dp #(
    parameter int EXP_TABLE_ADDR_BITS = gwfg_pkg::EXP_ADDR_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [55:0]                      s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_valid,
    input  logic [gwfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  gwfg_pkg::cmd_t                   cmd,
    output gwfg_pkg::status_t                status
);

    localparam int AB     = EXP_TABLE_ADDR_BITS;
    localparam int FRAC_W = 20 - AB;
    localparam int TAB_N  = (1 << AB) + 1;

    typedef logic [31:0] tab_t [TAB_N];

    function automatic tab_t build_tab();
        tab_t                t;
        logic [63:0]         h;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        logic [63:0]         e;
        logic [63:0]         prod;
        h    = 64'd1 << (35 - AB);
        term = 64'h8000_0000;
        sum  = 64'sh8000_0000;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * h) >> 31) / 64'(k);
            if (k % 2 == 1) sum = sum - $signed(term);
            else            sum = sum + $signed(term);
        end
        e    = sum;
        t[0] = 32'h8000_0000;
        for (int i = 1; i < TAB_N; i++) begin
            prod = ((64'(t[i-1]) * e) + 64'h4000_0000) >> 31;
            t[i] = prod[31:0];
        end
        return t;
    endfunction

    localparam tab_t EXP_TAB = build_tab();

    logic [31:0] centre_reg, width_reg;
    logic [31:0] ad_reg;
    logic [16:0] u_reg;
    logic        last_reg;
    logic [63:0] dd_reg, ss_reg;
    logic [64:0] r_reg;
    logic [19:0] n_reg, q_reg;
    logic [31:0] a_reg, b_reg;
    logic [16:0] g_reg;
    logic [32:0] ap_reg;
    logic        neg_reg;
    logic [64:0] m1_reg;
    logic [33:0] m2_reg;
    logic [63:0] acc_reg;
    logic        clip_reg;
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic [32:0] ma, mb;
    logic [65:0] prod;
    logic [32:0] d_w;
    logic [31:0] ad_w;
    logic [16:0] u_w;
    logic [64:0] r_sh, r_sub;
    logic        r_ge;
    logic [AB-1:0]   idx;
    logic [AB:0]     idx1;
    logic [FRAC_W-1:0] fr;
    logic [65:0] interp_sh;
    logic [31:0] g31, g_rnd;
    logic [17:0] gu;
    logic [16:0] gu_abs;
    logic [65:0] mag_full;
    logic [63:0] mag, ua, ua_new;
    logic [64:0] ua_sum;
    logic        clip_w;

    assign idx  = q_reg[19:FRAC_W];
    assign idx1 = {1'b0, idx} + 1'b1;
    assign fr   = q_reg[FRAC_W-1:0];
    assign gu   = {1'b0, g_reg} - {1'b0, u_reg};
    assign gu_abs = gu[17] ? 17'(-gu) : gu[16:0];

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            gwfg_pkg::OP_DD: begin
                ma = {1'b0, ad_reg};
                mb = {1'b0, ad_reg};
            end
            gwfg_pkg::OP_SS: begin
                ma = {1'b0, width_reg};
                mb = {1'b0, width_reg};
            end
            gwfg_pkg::OP_INTERP: begin
                ma = {1'b0, a_reg - b_reg};
                mb = 33'(fr);
            end
            gwfg_pkg::OP_PROD: begin
                ma = 33'(gu_abs);
                mb = 33'(g_reg);
            end
            gwfg_pkg::OP_MHI: begin
                ma = ap_reg;
                mb = {1'b0, dd_reg[63:32]};
            end
            gwfg_pkg::OP_MLO: begin
                ma = ap_reg;
                mb = {1'b0, dd_reg[31:0]};
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = 66'(ma) * 66'(mb);

    assign d_w  = {s_tdata[31], s_tdata[31:0]} - {centre_reg[31], centre_reg};
    assign ad_w = d_w[32] ? 32'(-d_w) : d_w[31:0];
    assign u_w  = (s_tdata[48:32] > 17'd65536) ? 17'd65536 : s_tdata[48:32];

    assign r_sh  = {r_reg[63:0], n_reg[19]};
    assign r_ge  = r_sh >= {1'b0, ss_reg};
    assign r_sub = r_sh - {1'b0, ss_reg};

    assign interp_sh = prod >> FRAC_W;
    assign g31   = a_reg - interp_sh[31:0];
    assign g_rnd = g31 + 32'd16384;

    always_comb begin
        mag_full = 66'(m1_reg) + 66'(m2_reg);
        mag      = (mag_full[65:64] != 2'b00) ? '1 : mag_full[63:0];
        ua       = acc_reg ^ 64'h8000_0000_0000_0000;
        ua_sum   = {1'b0, ua} + {1'b0, mag};
        clip_w   = 1'b0;
        if (!neg_reg) begin
            if (ua_sum[64]) begin
                ua_new = '1;
                clip_w = 1'b1;
            end else begin
                ua_new = ua_sum[63:0];
            end
        end else begin
            if (mag > ua) begin
                ua_new = '0;
                clip_w = 1'b1;
            end else begin
                ua_new = ua - mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_reg <= '0;
            width_reg  <= 32'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gwfg_pkg::REG_CENTRE: centre_reg <= cfg_data;
                gwfg_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            gwfg_pkg::OP_LOAD: begin
                ad_reg   <= ad_w;
                u_reg    <= u_w;
                last_reg <= s_tlast;
            end
            gwfg_pkg::OP_DD: dd_reg <= prod[63:0];
            gwfg_pkg::OP_SS: ss_reg <= prod[63:0];
            gwfg_pkg::OP_CHECK: begin
                r_reg <= 65'(dd_reg[63:5]);
                n_reg <= {dd_reg[4:0], 15'd0};
                q_reg <= '0;
                g_reg <= '0;
            end
            gwfg_pkg::OP_DIV: begin
                r_reg <= r_ge ? r_sub : r_sh;
                n_reg <= {n_reg[18:0], 1'b0};
                q_reg <= {q_reg[18:0], r_ge};
            end
            gwfg_pkg::OP_TAB: begin
                a_reg <= EXP_TAB[idx];
                b_reg <= EXP_TAB[idx1];
            end
            gwfg_pkg::OP_INTERP: g_reg <= g_rnd[31:15];
            gwfg_pkg::OP_PROD: begin
                ap_reg  <= prod[32:0];
                neg_reg <= gu[17];
            end
            gwfg_pkg::OP_MHI: m1_reg <= prod[64:0];
            gwfg_pkg::OP_MLO: m2_reg <= prod[65:32];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == gwfg_pkg::OP_ACC) begin
                acc_reg  <= ua_new ^ 64'h8000_0000_0000_0000;
                clip_reg <= clip_reg | clip_w;
            end else if (cmd.op == gwfg_pkg::OP_EMIT) begin
                acc_reg  <= '0;
                clip_reg <= 1'b0;
            end
            if (cmd.op == gwfg_pkg::OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == gwfg_pkg::OP_EMIT) begin
            if (width_reg == '0) begin
                m_data_reg <= 64'hFFFF_FFFF_0000_0000;
                m_user_reg <= 2'b01;
            end else begin
                m_data_reg <= acc_reg;
                m_user_reg <= {clip_reg, 1'b0};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign status.width_zero = (width_reg == '0);
    assign status.tail       = {5'd0, dd_reg} >= {ss_reg, 5'd0};
    assign status.last       = last_reg;
    assign status.out_busy   = m_valid_reg & ~m_tready;

endmodule

@@ rtl/gaussian_width_fit_gradient.sv @@
// Accumulates the least-squares width gradient (g - u) * d^2 * g of a Gaussian
// membership over a set of points, g = exp(-d^2 / (2 s^2)), d = x - m. Each
// point is accepted only after the previous one is done, which is sooner when
// the point lies beyond the exp table or the width is zero, a pace set by the
// 20-step bit-serial divider and the single shared 33x33 multiplier, which
// handle every point one after another. The sum, signed Q32.32 and saturating,
// leaves on the last point of a set; a waiting result does not block new
// points until the next last point. Width zero gives -1.0 with width_zero set.
module gaussian_width_fit_gradient #(
    parameter int EXP_TABLE_ADDR_BITS = gwfg_pkg::EXP_ADDR_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [55:0]                      s_tdata,   // coord[31:0], target[48:32], zero pad
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // gradient_sum[63:0]
    output logic [1:0]                       m_tuser,   // width_zero[0], saturated[1]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gwfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    gwfg_pkg::cmd_t    cmd;
    gwfg_pkg::status_t status;

    assign cfg_ready = 1'b1;

    gwfg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gwfg_dp #(
        .EXP_TABLE_ADDR_BITS (EXP_TABLE_ADDR_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
